// ----- rtl/core/radix5_real_fft_synthesis_butterfly_core_defines.svh -----
// ----------------------------------------------------------------------------
// radix5_real_fft_synthesis_butterfly_core_defines
// Assertion macros used by the butterfly core sequencer (r5rfb_ctrl).
// ----------------------------------------------------------------------------
`ifndef RADIX5_REAL_FFT_SYNTHESIS_BUTTERFLY_CORE_DEFINES_SVH
`define RADIX5_REAL_FFT_SYNTHESIS_BUTTERFLY_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// check cons in the cycle after ante
`define R5RFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
// check cons in the same cycle as ante
`define R5RFB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`else
`define R5RFB_ASSERT_NEXT(lbl, ante, cons, msg)
`define R5RFB_ASSERT_SAME(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/core/r5rfb_pkg.sv -----
// ----------------------------------------------------------------------------
// r5rfb_pkg
// Types, constants and the micro-op sequence of the radix-5 synthesis core.
// ----------------------------------------------------------------------------
package r5rfb_pkg;

  localparam logic [1:0] FUNC_START    = 2'd0;
  localparam logic [1:0] FUNC_INTERIOR = 2'd1;
  localparam logic [1:0] FUNC_CLOSE    = 2'd2;
  localparam logic [1:0] FUNC_NONE     = 2'd3;

  localparam logic [1:0] CFG_STEP_RE = 2'd0;
  localparam logic [1:0] CFG_STEP_IM = 2'd1;

  localparam int NUM_UOPS = 64;
  localparam logic [5:0] LAST_UOP = 6'(NUM_UOPS - 1);

  // Q2.30 kernel constants
  localparam logic signed [31:0] K_C1 = 32'sd331804471;
  localparam logic signed [31:0] K_S1 = -32'sd1021189159;
  localparam logic signed [31:0] K_C2 = -32'sd868675383;
  localparam logic signed [31:0] K_S2 = -32'sd631129609;
  localparam logic signed [39:0] TW_ONE = 40'sd1073741824;

  typedef enum logic [4:0] {
    OA_SA, OA_SB, OA_SC, OA_SD, OA_SE, OA_SG, OA_SH, OA_SI,
    OA_Z1RE, OA_Z1IM, OA_Z2RE, OA_Z2IM, OA_Z3RE, OA_Z3IM, OA_Z4RE, OA_Z4IM,
    OA_W1RE, OA_W1IM, OA_W2RE, OA_W2IM, OA_W3RE, OA_W3IM,
    OA_STRE, OA_STIM
  } opa_t;

  typedef enum logic [3:0] {
    OB_C1, OB_S1, OB_C2, OB_S2,
    OB_W1RE, OB_W1IM, OB_W2RE, OB_W2IM, OB_W3RE, OB_W3IM, OB_W4RE, OB_W4IM
  } opb_t;

  typedef enum logic [2:0] {
    INIT_ACC, INIT_ZERO, INIT_T0RE, INIT_T0IM, INIT_TWRE, INIT_TWIM
  } init_t;

  typedef enum logic [4:0] {
    D_NONE,
    D_Z1RE, D_Z1IM, D_Z2RE, D_Z2IM, D_Z3RE, D_Z3IM, D_Z4RE, D_Z4IM,
    D_W2RE, D_W2IM, D_W3RE, D_W3IM, D_W4RE, D_W4IM,
    D_R1RE, D_R1IM, D_R2RE, D_R2IM, D_R3RE, D_R3IM, D_R4RE, D_R4IM,
    D_NTRE, D_NTIM
  } dst_t;

  typedef struct packed {
    opa_t  a;
    opb_t  b;
    init_t init;
    logic  neg;
    dst_t  dst;
  } uop_t;

  typedef struct packed {
    logic load;
    logic issue;
    uop_t uop;
    logic finish;
  } cmd_t;

  function automatic uop_t mk(input opa_t a, input opb_t b, input init_t i,
                              input logic n, input dst_t d);
    uop_t u;
    u.a = a;
    u.b = b;
    u.init = i;
    u.neg = n;
    u.dst = d;
    return u;
  endfunction

  function automatic logic signed [23:0] sat_smp(input logic signed [39:0] v);
    logic signed [23:0] r;
    if (v > 40'sd8388607) r = 24'sh7fffff;
    else if (v < -40'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat_tw(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) r = 32'sh7fffffff;
    else if (v < -40'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Kernel sums, twiddle powers, output rotation, twiddle advance.
  function automatic uop_t uop_rom(input logic [5:0] idx);
    uop_t u;
    case (idx)
      6'd0:  u = mk(OA_SA, OB_C1, INIT_T0RE, 1'b0, D_NONE);
      6'd1:  u = mk(OA_SB, OB_S1, INIT_ACC,  1'b0, D_NONE);
      6'd2:  u = mk(OA_SC, OB_C2, INIT_ACC,  1'b0, D_NONE);
      6'd3:  u = mk(OA_SD, OB_S2, INIT_ACC,  1'b0, D_Z1RE);
      6'd4:  u = mk(OA_SE, OB_S1, INIT_T0IM, 1'b1, D_NONE);
      6'd5:  u = mk(OA_SG, OB_C1, INIT_ACC,  1'b0, D_NONE);
      6'd6:  u = mk(OA_SH, OB_S2, INIT_ACC,  1'b1, D_NONE);
      6'd7:  u = mk(OA_SI, OB_C2, INIT_ACC,  1'b0, D_Z1IM);
      6'd8:  u = mk(OA_SA, OB_C2, INIT_T0RE, 1'b0, D_NONE);
      6'd9:  u = mk(OA_SB, OB_S2, INIT_ACC,  1'b0, D_NONE);
      6'd10: u = mk(OA_SC, OB_C1, INIT_ACC,  1'b0, D_NONE);
      6'd11: u = mk(OA_SD, OB_S1, INIT_ACC,  1'b1, D_Z2RE);
      6'd12: u = mk(OA_SE, OB_S2, INIT_T0IM, 1'b1, D_NONE);
      6'd13: u = mk(OA_SG, OB_C2, INIT_ACC,  1'b0, D_NONE);
      6'd14: u = mk(OA_SH, OB_S1, INIT_ACC,  1'b0, D_NONE);
      6'd15: u = mk(OA_SI, OB_C1, INIT_ACC,  1'b0, D_Z2IM);
      6'd16: u = mk(OA_SA, OB_C2, INIT_T0RE, 1'b0, D_NONE);
      6'd17: u = mk(OA_SB, OB_S2, INIT_ACC,  1'b1, D_NONE);
      6'd18: u = mk(OA_SC, OB_C1, INIT_ACC,  1'b0, D_NONE);
      6'd19: u = mk(OA_SD, OB_S1, INIT_ACC,  1'b0, D_Z3RE);
      6'd20: u = mk(OA_SE, OB_S2, INIT_T0IM, 1'b0, D_NONE);
      6'd21: u = mk(OA_SG, OB_C2, INIT_ACC,  1'b0, D_NONE);
      6'd22: u = mk(OA_SH, OB_S1, INIT_ACC,  1'b1, D_NONE);
      6'd23: u = mk(OA_SI, OB_C1, INIT_ACC,  1'b0, D_Z3IM);
      6'd24: u = mk(OA_SA, OB_C1, INIT_T0RE, 1'b0, D_NONE);
      6'd25: u = mk(OA_SB, OB_S1, INIT_ACC,  1'b1, D_NONE);
      6'd26: u = mk(OA_SC, OB_C2, INIT_ACC,  1'b0, D_NONE);
      6'd27: u = mk(OA_SD, OB_S2, INIT_ACC,  1'b1, D_Z4RE);
      6'd28: u = mk(OA_SE, OB_S1, INIT_T0IM, 1'b0, D_NONE);
      6'd29: u = mk(OA_SG, OB_C1, INIT_ACC,  1'b0, D_NONE);
      6'd30: u = mk(OA_SH, OB_S2, INIT_ACC,  1'b0, D_NONE);
      6'd31: u = mk(OA_SI, OB_C2, INIT_ACC,  1'b0, D_Z4IM);
      6'd32: u = mk(OA_W1RE, OB_W1RE, INIT_ZERO, 1'b0, D_NONE);
      6'd33: u = mk(OA_W1IM, OB_W1IM, INIT_ACC,  1'b1, D_W2RE);
      6'd34: u = mk(OA_W1RE, OB_W1IM, INIT_ZERO, 1'b0, D_NONE);
      6'd35: u = mk(OA_W1IM, OB_W1RE, INIT_ACC,  1'b0, D_W2IM);
      6'd36: u = mk(OA_W2RE, OB_W1RE, INIT_ZERO, 1'b0, D_NONE);
      6'd37: u = mk(OA_W2IM, OB_W1IM, INIT_ACC,  1'b1, D_W3RE);
      6'd38: u = mk(OA_W2RE, OB_W1IM, INIT_ZERO, 1'b0, D_NONE);
      6'd39: u = mk(OA_W2IM, OB_W1RE, INIT_ACC,  1'b0, D_W3IM);
      6'd40: u = mk(OA_W3RE, OB_W1RE, INIT_ZERO, 1'b0, D_NONE);
      6'd41: u = mk(OA_W3IM, OB_W1IM, INIT_ACC,  1'b1, D_W4RE);
      6'd42: u = mk(OA_W3RE, OB_W1IM, INIT_ZERO, 1'b0, D_NONE);
      6'd43: u = mk(OA_W3IM, OB_W1RE, INIT_ACC,  1'b0, D_W4IM);
      6'd44: u = mk(OA_Z1RE, OB_W1RE, INIT_ZERO, 1'b0, D_NONE);
      6'd45: u = mk(OA_Z1IM, OB_W1IM, INIT_ACC,  1'b0, D_R1RE);
      6'd46: u = mk(OA_Z1IM, OB_W1RE, INIT_ZERO, 1'b0, D_NONE);
      6'd47: u = mk(OA_Z1RE, OB_W1IM, INIT_ACC,  1'b1, D_R1IM);
      6'd48: u = mk(OA_Z2RE, OB_W2RE, INIT_ZERO, 1'b0, D_NONE);
      6'd49: u = mk(OA_Z2IM, OB_W2IM, INIT_ACC,  1'b0, D_R2RE);
      6'd50: u = mk(OA_Z2IM, OB_W2RE, INIT_ZERO, 1'b0, D_NONE);
      6'd51: u = mk(OA_Z2RE, OB_W2IM, INIT_ACC,  1'b1, D_R2IM);
      6'd52: u = mk(OA_Z3RE, OB_W3RE, INIT_ZERO, 1'b0, D_NONE);
      6'd53: u = mk(OA_Z3IM, OB_W3IM, INIT_ACC,  1'b0, D_R3RE);
      6'd54: u = mk(OA_Z3IM, OB_W3RE, INIT_ZERO, 1'b0, D_NONE);
      6'd55: u = mk(OA_Z3RE, OB_W3IM, INIT_ACC,  1'b1, D_R3IM);
      6'd56: u = mk(OA_Z4RE, OB_W4RE, INIT_ZERO, 1'b0, D_NONE);
      6'd57: u = mk(OA_Z4IM, OB_W4IM, INIT_ACC,  1'b0, D_R4RE);
      6'd58: u = mk(OA_Z4IM, OB_W4RE, INIT_ZERO, 1'b0, D_NONE);
      6'd59: u = mk(OA_Z4RE, OB_W4IM, INIT_ACC,  1'b1, D_R4IM);
      6'd60: u = mk(OA_STRE, OB_W1RE, INIT_TWRE, 1'b0, D_NONE);
      6'd61: u = mk(OA_STIM, OB_W1IM, INIT_ACC,  1'b1, D_NTRE);
      6'd62: u = mk(OA_STRE, OB_W1IM, INIT_TWIM, 1'b0, D_NONE);
      6'd63: u = mk(OA_STIM, OB_W1RE, INIT_ACC,  1'b0, D_NTIM);
      default: u = mk(OA_SA, OB_C1, INIT_ACC, 1'b0, D_NONE);
    endcase
    return u;
  endfunction

endpackage

// ----- rtl/core/r5rfb_dpath.sv -----
// ----------------------------------------------------------------------------
// r5rfb_dpath
// Operand staging, shared rounding multiply-accumulate, twiddle and outputs.
// ----------------------------------------------------------------------------
module r5rfb_dpath (
  input  logic                clk,
  input  logic                rst,
  input  r5rfb_pkg::cmd_t     cmd,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic [1:0]          func,
  input  logic signed [23:0]  in0_re,
  input  logic signed [23:0]  in0_im,
  input  logic signed [23:0]  in1_re,
  input  logic signed [23:0]  in1_im,
  input  logic signed [23:0]  in2_re,
  input  logic signed [23:0]  in2_im,
  input  logic signed [23:0]  in3_re,
  input  logic signed [23:0]  in3_im,
  input  logic signed [23:0]  in4_re,
  input  logic signed [23:0]  in4_im,
  output logic signed [23:0]  out0_re,
  output logic signed [23:0]  out0_im,
  output logic signed [23:0]  out1_re,
  output logic signed [23:0]  out1_im,
  output logic signed [23:0]  out2_re,
  output logic signed [23:0]  out2_im,
  output logic signed [23:0]  out3_re,
  output logic signed [23:0]  out3_im,
  output logic signed [23:0]  out4_re,
  output logic signed [23:0]  out4_im
);

  logic signed [31:0] step_re, step_im, twre, twim;
  logic [1:0]         func_q;
  logic signed [23:0] t0re, t0im;
  logic signed [25:0] sa, sb, sc, sd, se, sg, sh, si;
  logic signed [24:0] pre, pim, qre, qim, rre_k, rim_k, sre, sim;
  logic signed [27:0] zre [4];
  logic signed [27:0] zim [4];
  logic signed [31:0] wre [3];
  logic signed [31:0] wim [3];
  logic signed [23:0] rre [4];
  logic signed [23:0] rim [4];
  logic signed [31:0] ntre, ntim;
  logic signed [23:0] ore [5];
  logic signed [23:0] oim [5];
  logic signed [31:0] opa, opb;
  logic signed [63:0] prod, prod_sum;
  logic signed [33:0] prod_rnd;
  logic               issue_q;
  r5rfb_pkg::uop_t    uop_q;
  logic signed [39:0] acc, acc_base, acc_term, acc_next;
  logic signed [39:0] z0re, z0im;

  // kernel terms per butterfly kind
  always_comb begin
    pre = 25'(in1_re);
    pim = 25'(in1_im);
    qre = 25'(in2_re);
    qim = 25'(in2_im);
    rre_k = 25'(in0_re);
    rim_k = -25'(in0_im);
    sre = 25'(in1_re);
    sim = -25'(in1_im);
    case (func)
      r5rfb_pkg::FUNC_START: begin
        pre = $signed({in1_re, 1'b0});
        pim = $signed({in1_im, 1'b0});
        qre = $signed({in2_re, 1'b0});
        qim = $signed({in2_im, 1'b0});
        rre_k = '0;
        rim_k = '0;
        sre = '0;
        sim = '0;
      end
      r5rfb_pkg::FUNC_INTERIOR: begin
        rre_k = 25'(in3_re);
        rim_k = -25'(in3_im);
        sre = 25'(in4_re);
        sim = -25'(in4_im);
      end
      default: begin
        qim = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func;
      t0re <= in0_re;
      t0im <= (func == r5rfb_pkg::FUNC_START) ? 24'sd0 : in0_im;
      sa <= 26'(pre) + 26'(rre_k);
      sb <= 26'(pim) - 26'(rim_k);
      sc <= 26'(qre) + 26'(sre);
      sd <= 26'(qim) - 26'(sim);
      se <= 26'(pre) - 26'(rre_k);
      sg <= 26'(pim) + 26'(rim_k);
      sh <= 26'(qre) - 26'(sre);
      si <= 26'(qim) + 26'(sim);
    end
  end

  always_comb begin
    case (cmd.uop.a)
      r5rfb_pkg::OA_SA:   opa = 32'(sa);
      r5rfb_pkg::OA_SB:   opa = 32'(sb);
      r5rfb_pkg::OA_SC:   opa = 32'(sc);
      r5rfb_pkg::OA_SD:   opa = 32'(sd);
      r5rfb_pkg::OA_SE:   opa = 32'(se);
      r5rfb_pkg::OA_SG:   opa = 32'(sg);
      r5rfb_pkg::OA_SH:   opa = 32'(sh);
      r5rfb_pkg::OA_SI:   opa = 32'(si);
      r5rfb_pkg::OA_Z1RE: opa = 32'(zre[0]);
      r5rfb_pkg::OA_Z1IM: opa = 32'(zim[0]);
      r5rfb_pkg::OA_Z2RE: opa = 32'(zre[1]);
      r5rfb_pkg::OA_Z2IM: opa = 32'(zim[1]);
      r5rfb_pkg::OA_Z3RE: opa = 32'(zre[2]);
      r5rfb_pkg::OA_Z3IM: opa = 32'(zim[2]);
      r5rfb_pkg::OA_Z4RE: opa = 32'(zre[3]);
      r5rfb_pkg::OA_Z4IM: opa = 32'(zim[3]);
      r5rfb_pkg::OA_W1RE: opa = twre;
      r5rfb_pkg::OA_W1IM: opa = twim;
      r5rfb_pkg::OA_W2RE: opa = wre[0];
      r5rfb_pkg::OA_W2IM: opa = wim[0];
      r5rfb_pkg::OA_W3RE: opa = wre[1];
      r5rfb_pkg::OA_W3IM: opa = wim[1];
      r5rfb_pkg::OA_STRE: opa = step_re;
      r5rfb_pkg::OA_STIM: opa = step_im;
      default:            opa = '0;
    endcase
    case (cmd.uop.b)
      r5rfb_pkg::OB_C1:   opb = r5rfb_pkg::K_C1;
      r5rfb_pkg::OB_S1:   opb = r5rfb_pkg::K_S1;
      r5rfb_pkg::OB_C2:   opb = r5rfb_pkg::K_C2;
      r5rfb_pkg::OB_S2:   opb = r5rfb_pkg::K_S2;
      r5rfb_pkg::OB_W1RE: opb = twre;
      r5rfb_pkg::OB_W1IM: opb = twim;
      r5rfb_pkg::OB_W2RE: opb = wre[0];
      r5rfb_pkg::OB_W2IM: opb = wim[0];
      r5rfb_pkg::OB_W3RE: opb = wre[1];
      r5rfb_pkg::OB_W3IM: opb = wim[1];
      r5rfb_pkg::OB_W4RE: opb = wre[2];
      r5rfb_pkg::OB_W4IM: opb = wim[2];
      default:            opb = '0;
    endcase
  end

  // multiply stage
  always_ff @(posedge clk) begin
    prod <= opa * opb;
    uop_q <= cmd.uop;
    if (rst) begin
      issue_q <= 1'b0;
    end else begin
      issue_q <= cmd.issue;
    end
  end

  // round half up, drop 30 fraction bits
  assign prod_sum = prod + 64'sd536870912;
  assign prod_rnd = prod_sum[63:30];

  always_comb begin
    case (uop_q.init)
      r5rfb_pkg::INIT_ACC:  acc_base = acc;
      r5rfb_pkg::INIT_ZERO: acc_base = '0;
      r5rfb_pkg::INIT_T0RE: acc_base = 40'(t0re);
      r5rfb_pkg::INIT_T0IM: acc_base = 40'(t0im);
      r5rfb_pkg::INIT_TWRE: acc_base = 40'(twre);
      r5rfb_pkg::INIT_TWIM: acc_base = 40'(twim);
      default:              acc_base = '0;
    endcase
    acc_term = uop_q.neg ? -40'(prod_rnd) : 40'(prod_rnd);
    acc_next = acc_base + acc_term;
  end

  always_ff @(posedge clk) begin
    if (issue_q) begin
      acc <= acc_next;
      case (uop_q.dst)
        r5rfb_pkg::D_Z1RE: zre[0] <= acc_next[27:0];
        r5rfb_pkg::D_Z1IM: zim[0] <= acc_next[27:0];
        r5rfb_pkg::D_Z2RE: zre[1] <= acc_next[27:0];
        r5rfb_pkg::D_Z2IM: zim[1] <= acc_next[27:0];
        r5rfb_pkg::D_Z3RE: zre[2] <= acc_next[27:0];
        r5rfb_pkg::D_Z3IM: zim[2] <= acc_next[27:0];
        r5rfb_pkg::D_Z4RE: zre[3] <= acc_next[27:0];
        r5rfb_pkg::D_Z4IM: zim[3] <= acc_next[27:0];
        r5rfb_pkg::D_W2RE: wre[0] <= r5rfb_pkg::sat_tw(acc_next);
        r5rfb_pkg::D_W2IM: wim[0] <= r5rfb_pkg::sat_tw(acc_next);
        r5rfb_pkg::D_W3RE: wre[1] <= r5rfb_pkg::sat_tw(acc_next);
        r5rfb_pkg::D_W3IM: wim[1] <= r5rfb_pkg::sat_tw(acc_next);
        r5rfb_pkg::D_W4RE: wre[2] <= r5rfb_pkg::sat_tw(acc_next);
        r5rfb_pkg::D_W4IM: wim[2] <= r5rfb_pkg::sat_tw(acc_next);
        r5rfb_pkg::D_R1RE: rre[0] <= r5rfb_pkg::sat_smp(acc_next);
        r5rfb_pkg::D_R1IM: rim[0] <= r5rfb_pkg::sat_smp(acc_next);
        r5rfb_pkg::D_R2RE: rre[1] <= r5rfb_pkg::sat_smp(acc_next);
        r5rfb_pkg::D_R2IM: rim[1] <= r5rfb_pkg::sat_smp(acc_next);
        r5rfb_pkg::D_R3RE: rre[2] <= r5rfb_pkg::sat_smp(acc_next);
        r5rfb_pkg::D_R3IM: rim[2] <= r5rfb_pkg::sat_smp(acc_next);
        r5rfb_pkg::D_R4RE: rre[3] <= r5rfb_pkg::sat_smp(acc_next);
        r5rfb_pkg::D_R4IM: rim[3] <= r5rfb_pkg::sat_smp(acc_next);
        r5rfb_pkg::D_NTRE: ntre <= r5rfb_pkg::sat_tw(acc_next);
        r5rfb_pkg::D_NTIM: ntim <= r5rfb_pkg::sat_tw(acc_next);
        default: ;
      endcase
    end
  end

  assign z0re = 40'(t0re) + 40'(sa) + 40'(sc);
  assign z0im = 40'(t0im) + 40'(sg) + 40'(si);

  // result word
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      ore[0] <= r5rfb_pkg::sat_smp(z0re);
      oim[0] <= (func_q == r5rfb_pkg::FUNC_INTERIOR) ? r5rfb_pkg::sat_smp(z0im) : '0;
      case (func_q)
        r5rfb_pkg::FUNC_START: begin
          ore[1] <= r5rfb_pkg::sat_smp(40'(zre[0]));
          ore[2] <= r5rfb_pkg::sat_smp(40'(zre[1]));
          ore[3] <= r5rfb_pkg::sat_smp(40'(zre[2]));
          ore[4] <= r5rfb_pkg::sat_smp(40'(zre[3]));
          oim[1] <= '0;
          oim[2] <= '0;
          oim[3] <= '0;
          oim[4] <= '0;
        end
        r5rfb_pkg::FUNC_INTERIOR: begin
          ore[1] <= rre[0];
          ore[2] <= rre[1];
          ore[3] <= rre[2];
          ore[4] <= rre[3];
          oim[1] <= rim[0];
          oim[2] <= rim[1];
          oim[3] <= rim[2];
          oim[4] <= rim[3];
        end
        default: begin
          ore[1] <= rre[0];
          ore[2] <= rre[1];
          ore[3] <= rre[2];
          ore[4] <= rre[3];
          oim[1] <= '0;
          oim[2] <= '0;
          oim[3] <= '0;
          oim[4] <= '0;
        end
      endcase
    end
  end

  // step registers and running twiddle
  always_ff @(posedge clk) begin
    if (rst) begin
      step_re <= '0;
      step_im <= '0;
      twre <= '0;
      twim <= '0;
    end else begin
      if (cfg_we && cfg_index == r5rfb_pkg::CFG_STEP_RE) step_re <= cfg_data;
      if (cfg_we && cfg_index == r5rfb_pkg::CFG_STEP_IM) step_im <= cfg_data;
      if (cmd.finish) begin
        case (func_q)
          r5rfb_pkg::FUNC_START: begin
            twre <= r5rfb_pkg::sat_tw(40'(step_re) + r5rfb_pkg::TW_ONE);
            twim <= step_im;
          end
          r5rfb_pkg::FUNC_INTERIOR: begin
            twre <= ntre;
            twim <= ntim;
          end
          default: ;
        endcase
      end
    end
  end

  assign out0_re = ore[0];
  assign out0_im = oim[0];
  assign out1_re = ore[1];
  assign out1_im = oim[1];
  assign out2_re = ore[2];
  assign out2_im = oim[2];
  assign out3_re = ore[3];
  assign out3_im = oim[3];
  assign out4_re = ore[4];
  assign out4_im = oim[4];

endmodule

// ----- rtl/core/r5rfb_ctrl.sv -----
// ----------------------------------------------------------------------------
// r5rfb_ctrl
// Sequencer: accepts a word, steps the micro-op list, hands off the result.
// ----------------------------------------------------------------------------
`include "radix5_real_fft_synthesis_butterfly_core_defines.svh"

module r5rfb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [1:0]      in_func,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output r5rfb_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t     state, state_next;
  logic [5:0] step, step_next;
  logic       out_valid_next;

  always_comb begin
    state_next = state;
    step_next = step;
    cmd.load = 1'b0;
    cmd.issue = 1'b0;
    cmd.finish = 1'b0;
    cmd.uop = r5rfb_pkg::uop_rom(step);
    case (state)
      ST_IDLE: begin
        // drop words with the unused code
        if (in_valid && in_func != r5rfb_pkg::FUNC_NONE) begin
          cmd.load = 1'b1;
          step_next = '0;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        step_next = step + 6'd1;
        if (step == r5rfb_pkg::LAST_UOP) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid || !out_stall) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    out_valid_next = cmd.finish || (out_valid && out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step <= step_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  `R5RFB_ASSERT_NEXT(a_start_run, state == ST_IDLE && in_valid && in_func != r5rfb_pkg::FUNC_NONE, state == ST_RUN, "accepted word did not start the sequence")
  `R5RFB_ASSERT_NEXT(a_run_ends, state == ST_RUN && step == r5rfb_pkg::LAST_UOP, state == ST_DRAIN, "sequence did not end after last micro-op")
  `R5RFB_ASSERT_SAME(a_no_overwrite, cmd.finish, !out_valid || !out_stall, "result overwritten while stalled")
  `R5RFB_ASSERT_NEXT(a_finish_valid, cmd.finish, out_valid, "finished result not presented")

endmodule

// ----- rtl/core/radix5_real_fft_synthesis_butterfly_core.sv -----
// ----------------------------------------------------------------------------
// radix5_real_fft_synthesis_butterfly_core
// Sequence: after input accept, 64 multiply steps on one shared 32x32
//   multiplier, one accumulate drain, one result load, then out_valid.
// Words do not overlap: in_stall stays high until the result is loaded.
// Reset: synchronous; clears sequencer, step registers and twiddle to zero.
// ----------------------------------------------------------------------------
module radix5_real_fft_synthesis_butterfly_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         func,
  input  logic signed [23:0] in0_re,
  input  logic signed [23:0] in0_im,
  input  logic signed [23:0] in1_re,
  input  logic signed [23:0] in1_im,
  input  logic signed [23:0] in2_re,
  input  logic signed [23:0] in2_im,
  input  logic signed [23:0] in3_re,
  input  logic signed [23:0] in3_im,
  input  logic signed [23:0] in4_re,
  input  logic signed [23:0] in4_im,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out0_re,
  output logic signed [23:0] out0_im,
  output logic signed [23:0] out1_re,
  output logic signed [23:0] out1_im,
  output logic signed [23:0] out2_re,
  output logic signed [23:0] out2_im,
  output logic signed [23:0] out3_re,
  output logic signed [23:0] out3_im,
  output logic signed [23:0] out4_re,
  output logic signed [23:0] out4_im,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  r5rfb_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  r5rfb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_func   (func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  r5rfb_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .func      (func),
    .in0_re    (in0_re),
    .in0_im    (in0_im),
    .in1_re    (in1_re),
    .in1_im    (in1_im),
    .in2_re    (in2_re),
    .in2_im    (in2_im),
    .in3_re    (in3_re),
    .in3_im    (in3_im),
    .in4_re    (in4_re),
    .in4_im    (in4_im),
    .out0_re   (out0_re),
    .out0_im   (out0_im),
    .out1_re   (out1_re),
    .out1_im   (out1_im),
    .out2_re   (out2_re),
    .out2_im   (out2_im),
    .out3_re   (out3_re),
    .out3_im   (out3_im),
    .out4_re   (out4_re),
    .out4_im   (out4_im)
  );

endmodule
